FILE: src/acrc_pkg.sv
// Shared types, constants and character helpers for the ASCII CRC-32 line checker.
`timescale 1ns / 1ps

package acrc_pkg;

   // CRC-32 without reflection, preset to all ones.
   localparam logic [31:0] CRC_POLY   = 32'h04C1_1DB7;
   localparam logic [31:0] CRC_PRESET = 32'hFFFF_FFFF;

   // Line terminator and trailer layout.
   localparam logic [7:0] LINE_END    = 8'h0A;
   localparam logic [2:0] MARK_LAST   = 3'd4;   // index of ':' in ",CRC:"
   localparam int         HIST_DEPTH  = 4;      // CRC values kept behind the marker
   localparam logic [3:0] HEX_DIGITS  = 4'd8;

   // One result of a finished line.
   typedef struct packed {
      logic [31:0] payload_crc;
      logic        marker_found;
      logic        frame_ok;
   } result_type;

   // Character of the marker ",CRC:" at a given position.
   function automatic logic [7:0] marker_char(input logic [2:0] pos);
      logic [7:0] ch;
      unique case (pos)
         3'd0:    ch = 8'h2C;   // ','
         3'd1:    ch = 8'h43;   // 'C'
         3'd2:    ch = 8'h52;   // 'R'
         3'd3:    ch = 8'h43;   // 'C'
         3'd4:    ch = 8'h3A;   // ':'
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // Uppercase ASCII hex digit for one nibble.
   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] ch;
      if (nib < 4'd10) begin
         ch = 8'h30 + {4'h0, nib};
      end else begin
         ch = 8'h37 + {4'h0, nib};
      end
      return ch;
   endfunction

endpackage

FILE: src/acrc_crc_step.sv
// Unrolled one-byte update of the MSB-first CRC-32 register.
`timescale 1ns / 1ps

module acrc_crc_step (
   input  logic [31:0] crc_in,
   input  logic [7:0]  data_in,
   output logic [31:0] crc_out
);

   // Eight shift-and-reduce steps, most significant data bit first.
   always_comb begin
      logic [31:0] acc;
      acc = crc_in ^ {data_in, 24'h000000};
      for (int k = 0; k < 8; k++) begin
         if (acc[31]) begin
            acc = {acc[30:0], 1'b0} ^ acrc_pkg::CRC_POLY;
         end else begin
            acc = {acc[30:0], 1'b0};
         end
      end
      crc_out = acc;
   end

endmodule

FILE: src/acrc_line_state.sv
// Per-line state: running CRC, marker search, CRC snapshot and trailer digit check.
`timescale 1ns / 1ps

module acrc_line_state (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    byte_valid,
   input  logic [7:0]              byte_data,
   output logic                    line_done,
   output acrc_pkg::result_type    line_result
);

   logic [31:0] run_crc_ff,  run_crc_in;
   logic [31:0] hist_ff [acrc_pkg::HIST_DEPTH];
   logic [31:0] hist_in [acrc_pkg::HIST_DEPTH];
   logic [2:0]  mark_prog_ff, mark_prog_in;
   logic        seen_ff,      seen_in;
   logic [31:0] snap_ff,      snap_in;
   logic [3:0]  hex_idx_ff,   hex_idx_in;
   logic        mismatch_ff,  mismatch_in;

   logic [31:0] crc_next;
   logic        is_end;
   logic        mark_hit;
   logic        completed;
   logic [2:0]  nib_sel;
   logic [3:0]  want_nib;
   logic [7:0]  want_char;

   acrc_crc_step u_crc_step (
      .crc_in  (run_crc_ff),
      .data_in (byte_data),
      .crc_out (crc_next)
   );

   // Decode the current byte against the marker and the expected hex digit.
   assign is_end    = (byte_data == acrc_pkg::LINE_END);
   assign mark_hit  = (byte_data == acrc_pkg::marker_char(mark_prog_ff));
   assign completed = mark_hit && (mark_prog_ff == acrc_pkg::MARK_LAST);
   assign nib_sel   = 3'd7 - hex_idx_ff[2:0];
   assign want_nib  = snap_ff[{nib_sel, 2'b00} +: 4];
   assign want_char = acrc_pkg::hex_char(want_nib);

   // Result of a line, valid when the line-end byte is taken.
   assign line_done                = byte_valid && is_end;
   assign line_result.frame_ok     = seen_ff && hex_idx_ff[3] && !mismatch_ff;
   assign line_result.marker_found = seen_ff;
   assign line_result.payload_crc  = seen_ff ? snap_ff : 32'h0000_0000;

   // Next-state logic for one accepted byte.
   always_comb begin
      run_crc_in   = run_crc_ff;
      hist_in      = hist_ff;
      mark_prog_in = mark_prog_ff;
      seen_in      = seen_ff;
      snap_in      = snap_ff;
      hex_idx_in   = hex_idx_ff;
      mismatch_in  = mismatch_ff;
      if (byte_valid) begin
         if (is_end) begin
            run_crc_in = acrc_pkg::CRC_PRESET;
            for (int k = 0; k < acrc_pkg::HIST_DEPTH; k++) begin
               hist_in[k] = acrc_pkg::CRC_PRESET;
            end
            mark_prog_in = 3'd0;
            seen_in      = 1'b0;
            hex_idx_in   = 4'd0;
            mismatch_in  = 1'b0;
         end else begin
            hist_in[0] = run_crc_ff;
            for (int k = 1; k < acrc_pkg::HIST_DEPTH; k++) begin
               hist_in[k] = hist_ff[k-1];
            end
            run_crc_in = crc_next;

            if (completed) begin
               mark_prog_in = 3'd0;
            end else if (mark_hit) begin
               mark_prog_in = mark_prog_ff + 3'd1;
            end else if (byte_data == acrc_pkg::marker_char(3'd0)) begin
               mark_prog_in = 3'd1;
            end else begin
               mark_prog_in = 3'd0;
            end

            // The oldest history entry holds the CRC before the marker's comma.
            if (completed) begin
               seen_in     = 1'b1;
               snap_in     = ~hist_ff[acrc_pkg::HIST_DEPTH-1];
               hex_idx_in  = 4'd0;
               mismatch_in = 1'b0;
            end else if (seen_ff && (hex_idx_ff < acrc_pkg::HEX_DIGITS)) begin
               if (byte_data != want_char) begin
                  mismatch_in = 1'b1;
               end
               hex_idx_in = hex_idx_ff + 4'd1;
            end
         end
      end
   end

   // Control state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_crc_ff   <= acrc_pkg::CRC_PRESET;
         for (int k = 0; k < acrc_pkg::HIST_DEPTH; k++) begin
            hist_ff[k] <= acrc_pkg::CRC_PRESET;
         end
         mark_prog_ff <= 3'd0;
         seen_ff      <= 1'b0;
         hex_idx_ff   <= 4'd0;
         mismatch_ff  <= 1'b0;
      end else begin
         run_crc_ff   <= run_crc_in;
         hist_ff      <= hist_in;
         mark_prog_ff <= mark_prog_in;
         seen_ff      <= seen_in;
         hex_idx_ff   <= hex_idx_in;
         mismatch_ff  <= mismatch_in;
      end
   end

   // Snapshot is only read while a marker has been seen.
   always_ff @(posedge clock) begin
      snap_ff <= snap_in;
   end

   // The digit counter never runs past the trailer length.
   a_hex_idx_range: assert property (@(posedge clock) disable iff (reset)
      hex_idx_ff <= acrc_pkg::HEX_DIGITS)
      else $error("hex digit counter out of range");

   // Marker progress stays below the marker length.
   a_mark_range: assert property (@(posedge clock) disable iff (reset)
      mark_prog_ff <= acrc_pkg::MARK_LAST)
      else $error("marker progress out of range");

   // Digits are only counted after a marker.
   a_idx_needs_marker: assert property (@(posedge clock) disable iff (reset)
      !seen_ff |-> (hex_idx_ff == 4'd0) && !mismatch_ff)
      else $error("trailer digits counted without a marker");

   // A line end clears the line state.
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      line_done |=> !seen_ff && (run_crc_ff == acrc_pkg::CRC_PRESET))
      else $error("line state not cleared after line end");

endmodule

FILE: src/ascii_crc32_line_checker.sv
// Top level of the ASCII CRC-32 line checker: stream ports and result register.
`timescale 1ns / 1ps
//
// Checks text lines that end in a ",CRC:" trailer followed by eight uppercase
// hex digits. Characters enter on the req_ stream, one byte per transfer.
// Every byte except 0x0A only updates the line state; a 0x0A byte ends the
// line and produces one transfer on the rsp_ stream with the pass flag, the
// marker flag and the CRC-32 (poly 04C11DB7, preset all ones, inverted) of
// the bytes before the last marker, or zero when no marker was seen.
// Throughput is one byte per cycle: the CRC update is an unrolled eight-bit
// step between the line-state registers. The result is loaded into the output
// register in the cycle after the line-end transfer and stays until taken.
// While a result waits, bytes are still accepted as long as the receiver
// takes the result in the same cycle or no result is pending; a stalled
// receiver holds off req_tready only while the output register is full.
// Synchronous reset clears the line state and drops rsp_tvalid.
//
module ascii_crc32_line_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] data_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata     // [0] frame_ok, [1] marker_found,
                                     // [33:2] payload_crc, [39:34] zero
);

   logic                 accept;
   logic                 line_done;
   acrc_pkg::result_type line_result;
   logic                 rsp_valid_ff, rsp_valid_in;
   acrc_pkg::result_type rsp_data_ff,  rsp_data_in;

   // A byte can enter whenever the result register is free or being emptied.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   acrc_line_state u_line_state (
      .clock       (clock),
      .reset       (reset),
      .byte_valid  (accept),
      .byte_data   (req_tdata),
      .line_done   (line_done),
      .line_result (line_result)
   );

   // Result register load and release.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (line_done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = line_result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b000000, rsp_data_ff};

   // A line-end transfer always leaves a result pending in the next cycle.
   a_end_gives_result: assert property (@(posedge clock) disable iff (reset)
      line_done |=> rsp_tvalid)
      else $error("line end did not produce a result");

   // A pass implies that a marker was found.
   a_ok_needs_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_data_ff.frame_ok |-> rsp_data_ff.marker_found)
      else $error("pass reported without a marker");

   // Without a marker the reported CRC is zero.
   a_no_marker_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_data_ff.marker_found |-> (rsp_data_ff.payload_crc == 32'h0))
      else $error("nonzero CRC reported without a marker");

endmodule

FILE: dv/ascii_crc32_line_checker_tb.sv
// Self-checking testbench for the ASCII CRC-32 line checker.
`timescale 1ns / 1ps

module ascii_crc32_line_checker_tb;

   localparam int                    MARK_LEN     = 5;
   localparam logic [8*MARK_LEN-1:0] MARKER_TEXT  = ",CRC:";
   localparam logic [127:0]          HEX_SET      = "0123456789ABCDEF";
   localparam int                    RANDOM_BYTES = 950;
   localparam int                    DRAIN_LIMIT  = 20000;
   localparam int                    TAIL_CYCLES  = 8;

   // Shapes of generated lines.
   typedef enum logic [2:0] {
      LN_GOOD,
      LN_LOWER,
      LN_WRONG,
      LN_SHORT,
      LN_EXTRA,
      LN_TWO_MARKS,
      LN_NOISE
   } line_kind_type;

   // Ready patterns of the result receiver.
   typedef enum logic [1:0] {
      RX_OPEN,
      RX_COIN,
      RX_SPARSE,
      RX_STRIDE
   } rx_mode_type;

   // One directed byte; line ends may carry a verdict typed in by hand.
   typedef struct packed {
      logic [7:0]           data;
      logic                 typed;
      acrc_pkg::result_type want;
   } dir_row_type;

   localparam dir_row_type DIR_ROWS [25] = '{
      '{8'h0A, 1'b1, '{32'h0000_0000, 1'b0, 1'b0}},   // empty line right after reset
      '{8'h00, 1'b0, '0},
      '{8'hFF, 1'b0, '0},
      '{8'h0A, 1'b1, '{32'h0000_0000, 1'b0, 1'b0}},   // no marker at all
      '{",",   1'b0, '0},
      '{"C",   1'b0, '0},
      '{"R",   1'b0, '0},
      '{"C",   1'b0, '0},
      '{":",   1'b0, '0},
      '{"0",   1'b0, '0},
      '{"0",   1'b0, '0},
      '{"0",   1'b0, '0},
      '{"0",   1'b0, '0},
      '{"0",   1'b0, '0},
      '{"0",   1'b0, '0},
      '{"0",   1'b0, '0},
      '{"0",   1'b0, '0},
      '{8'h0A, 1'b1, '{32'h0000_0000, 1'b1, 1'b1}},   // empty payload, good trailer
      '{",",   1'b0, '0},
      '{"C",   1'b0, '0},
      '{"R",   1'b0, '0},
      '{"C",   1'b0, '0},
      '{":",   1'b0, '0},
      '{"0",   1'b0, '0},
      '{8'h0A, 1'b1, '{32'h0000_0000, 1'b1, 1'b0}}    // trailer cut short
   };

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;    // [7:0] data_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;             // [0] frame_ok, [1] marker_found,
                                       // [33:2] payload_crc, [39:34] zero

   // Predictor state for the line in progress.
   logic [31:0] line_crc;
   logic [31:0] crc_behind [MARK_LEN];
   logic [2:0]  mark_pos;
   logic        mark_seen;
   logic [31:0] mark_crc;
   logic [3:0]  digit_pos;
   logic        digit_bad;

   acrc_pkg::result_type verdicts_due [$];
   logic [7:0]  line_buf [$];
   string       noise_set = ",CRC:0123456789ABCDEFabcdef";

   int          burst_left    = 0;
   int          bytes_sent    = 0;
   int          lines_checked = 0;
   int          lines_passed  = 0;
   int          lines_marked  = 0;
   int          mismatches    = 0;

   rx_mode_type rx_mode  = RX_OPEN;
   int          rx_left  = 0;
   logic [1:0]  rx_phase = 2'd0;

   ascii_crc32_line_checker u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Clock generation.
   initial begin
      forever #2 clock = ~clock;
   end

   // One MSB-first CRC-32 step over a byte.
   function automatic logic [31:0] crc_step(input logic [31:0] r, input logic [7:0] b);
      logic [31:0] acc;
      acc = r ^ {b, 24'h0};
      for (int k = 0; k < 8; k++) begin
         acc = acc[31] ? ((acc << 1) ^ acrc_pkg::CRC_POLY) : (acc << 1);
      end
      return acc;
   endfunction

   function automatic logic [7:0] marker_at(input int pos);
      return MARKER_TEXT[8*(MARK_LEN-1-pos) +: 8];
   endfunction

   function automatic logic [7:0] digit_char(input logic [3:0] nib);
      return HEX_SET[8*(15-nib) +: 8];
   endfunction

   task automatic clear_line_state();
      line_crc = acrc_pkg::CRC_PRESET;
      foreach (crc_behind[k]) crc_behind[k] = acrc_pkg::CRC_PRESET;
      mark_pos  = 3'd0;
      mark_seen = 1'b0;
      mark_crc  = 32'h0;
      digit_pos = 4'd0;
      digit_bad = 1'b0;
   endtask

   // Advances the predicted line state by one byte; a line end yields a verdict.
   task automatic crc_trailer_predict(input logic [7:0] b, output bit has_res,
                                      output acrc_pkg::result_type res);
      logic completed;
      logic [7:0] want;
      has_res = 1'b0;
      res = '0;
      if (b == acrc_pkg::LINE_END) begin
         has_res          = 1'b1;
         res.frame_ok     = mark_seen && digit_pos >= acrc_pkg::HEX_DIGITS && !digit_bad;
         res.marker_found = mark_seen;
         res.payload_crc  = mark_seen ? mark_crc : 32'h0;
         clear_line_state();
      end else begin
         for (int k = MARK_LEN - 1; k > 0; k--) crc_behind[k] = crc_behind[k-1];
         crc_behind[0] = line_crc;
         line_crc = crc_step(line_crc, b);

         // Marker tracking; a stray comma restarts the match at one.
         completed = 1'b0;
         if (mark_pos < MARK_LEN && b == marker_at(mark_pos)) begin
            mark_pos = mark_pos + 3'd1;
            if (mark_pos == MARK_LEN) begin
               completed = 1'b1;
               mark_pos  = 3'd0;
            end
         end else begin
            mark_pos = (b == marker_at(0)) ? 3'd1 : 3'd0;
         end

         // The CRC before the comma is the one from five bytes back.
         if (completed) begin
            mark_seen = 1'b1;
            mark_crc  = ~crc_behind[MARK_LEN-1];
            digit_pos = 4'd0;
            digit_bad = 1'b0;
         end else if (mark_seen && digit_pos < acrc_pkg::HEX_DIGITS) begin
            want = digit_char(mark_crc[28 - 4*digit_pos +: 4]);
            if (b != want) digit_bad = 1'b1;
            digit_pos = digit_pos + 4'd1;
         end
      end
   endtask

   // Stimulus byte helpers.
   function automatic logic [7:0] payload_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (b == acrc_pkg::LINE_END);
      return b;
   endfunction

   function automatic logic [7:0] noise_byte();
      if ($urandom_range(0, 3) == 0) return payload_byte();
      return noise_set[$urandom_range(0, noise_set.len() - 1)];
   endfunction

   function automatic logic [31:0] buf_crc();
      logic [31:0] r;
      r = acrc_pkg::CRC_PRESET;
      foreach (line_buf[i]) r = crc_step(r, line_buf[i]);
      return ~r;
   endfunction

   // Adds one byte at the end of the line being built.
   task automatic append_byte(input logic [7:0] b);
      line_buf.insert(line_buf.size(), b);
   endtask

   // Appends the marker and the correct uppercase digits for the text so far.
   task automatic append_trailer();
      logic [31:0] sum;
      sum = buf_crc();
      for (int k = 0; k < MARK_LEN; k++) append_byte(marker_at(k));
      for (int k = 0; k < acrc_pkg::HEX_DIGITS; k++) begin
         append_byte(digit_char(sum[28 - 4*k +: 4]));
      end
   endtask

   // Spoils one of the last eight digits, either by case or by a flipped bit.
   task automatic corrupt_digit(input line_kind_type kind);
      int pos;
      pos = line_buf.size() - acrc_pkg::HEX_DIGITS
            + $urandom_range(0, acrc_pkg::HEX_DIGITS - 1);
      if (kind == LN_LOWER) begin
         if (line_buf[pos] >= "A") line_buf[pos] = line_buf[pos] + 8'h20;
         else line_buf[pos] = "a" + 8'($urandom_range(0, 5));
      end else begin
         line_buf[pos] = line_buf[pos] ^ (8'h01 << $urandom_range(0, 7));
      end
   endtask

   task automatic build_line(input line_kind_type kind);
      int n;
      line_buf.delete();
      if (kind == LN_NOISE) begin
         n = $urandom_range(0, 14);
         repeat (n) append_byte(noise_byte());
      end else begin
         n = $urandom_range(0, 8);
         repeat (n) append_byte(payload_byte());
         append_trailer();
         case (kind)
            LN_LOWER, LN_WRONG: begin
               corrupt_digit(kind);
            end
            LN_SHORT: begin
               n = $urandom_range(1, acrc_pkg::HEX_DIGITS);
               repeat (n) void'(line_buf.pop_back());
            end
            LN_EXTRA: begin
               n = $urandom_range(1, 4);
               repeat (n) append_byte(noise_byte());
            end
            LN_TWO_MARKS: begin
               // Only the last marker counts, so a bad first trailer may still pass.
               if ($urandom_range(0, 1) == 1) corrupt_digit(LN_WRONG);
               n = $urandom_range(0, 3);
               repeat (n) append_byte(noise_byte());
               append_trailer();
            end
            default: begin
            end
         endcase
      end
      append_byte(acrc_pkg::LINE_END);
   endtask

   // Sends one byte in bursts with random gaps and records its verdict, if any.
   task automatic send_byte(input logic [7:0] b, input logic typed,
                            input acrc_pkg::result_type want);
      int gap;
      bit has_res;
      acrc_pkg::result_type res;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      burst_left--;
      bytes_sent++;
      crc_trailer_predict(b, has_res, res);
      if (has_res) verdicts_due.insert(verdicts_due.size(), typed ? want : res);
   endtask

   // Holds the sender off until every verdict has come out.
   task automatic wait_all_verdicts();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (verdicts_due.size() != 0);
   endtask

   // Receiver ready pattern, switching to a randomly chosen mode whenever its mode counter runs out.
   always @(posedge clock) begin
      if (rx_left == 0) begin
         rx_mode <= rx_mode_type'($urandom_range(0, 3));
         rx_left <= $urandom_range(16, 80);
      end else begin
         rx_left <= rx_left - 1;
      end
      rx_phase <= rx_phase + 2'd1;
      case (rx_mode)
         RX_OPEN:   rsp_tready <= 1'b1;
         RX_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
         RX_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
         default:   rsp_tready <= (rx_phase == 2'd3);
      endcase
   end

   // Result checker: every transfer is compared with the oldest verdict due.
   always @(posedge clock) begin
      acrc_pkg::result_type got;
      acrc_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[33:0];
         if (verdicts_due.size() == 0) begin
            $error("Unexpected result transfer: %h", rsp_tdata);
            mismatches++;
         end else begin
            want = verdicts_due.pop_front();
            lines_checked++;
            if (got.frame_ok) lines_passed++;
            if (got.marker_found) lines_marked++;
            if (got.frame_ok !== want.frame_ok) begin
               $error("frame_ok: expected %0b, got %0b", want.frame_ok, got.frame_ok);
               mismatches++;
            end
            if (got.marker_found !== want.marker_found) begin
               $error("marker_found: expected %0b, got %0b",
                      want.marker_found, got.marker_found);
               mismatches++;
            end
            if (got.payload_crc !== want.payload_crc) begin
               $error("payload_crc: expected %h, got %h", want.payload_crc, got.payload_crc);
               mismatches++;
            end
            if (rsp_tdata[39:34] !== 6'h00) begin
               $error("padding: expected %h, got %h", 6'h00, rsp_tdata[39:34]);
               mismatches++;
            end
         end
      end
   end

   // Main sequence: reset, directed rows, random lines, drain and verdict.
   initial begin
      int            drain_wait;
      int            pick;
      line_kind_type kind;
      clear_line_state();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (DIR_ROWS[i]) send_byte(DIR_ROWS[i].data, DIR_ROWS[i].typed, DIR_ROWS[i].want);
      wait_all_verdicts();

      while (bytes_sent < $size(DIR_ROWS) + RANDOM_BYTES) begin
         pick = $urandom_range(0, 99);
         if (pick < 40)      kind = LN_GOOD;
         else if (pick < 50) kind = LN_LOWER;
         else if (pick < 60) kind = LN_WRONG;
         else if (pick < 70) kind = LN_SHORT;
         else if (pick < 80) kind = LN_EXTRA;
         else if (pick < 90) kind = LN_TWO_MARKS;
         else                kind = LN_NOISE;
         build_line(kind);
         foreach (line_buf[i]) send_byte(line_buf[i], 1'b0, '0);
         if ($urandom_range(0, 15) == 0) wait_all_verdicts();
      end

      // Let the last verdicts come out, then let the bench idle before the final tally.
      req_tvalid <= 1'b0;
      drain_wait = 0;
      while (verdicts_due.size() != 0 && drain_wait < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_wait++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (verdicts_due.size() != 0) begin
         $error("%0d verdicts never arrived", verdicts_due.size());
         mismatches++;
      end

      $display("Sent %0d bytes; checked %0d lines, %0d with a marker, %0d passing.",
               bytes_sent, lines_checked, lines_marked, lines_passed);
      $display("Lines held good, lowercase, wrong, short, padded and repeated trailers.");
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
